// File: rtl/tcgr_pkg.sv
// tcgr_pkg: field widths, register indexes, character codes and the microcode
// store of the text console glyph renderer.
// Depends on nothing; used by text_console_glyph_renderer.
package tcgr_pkg;

    // Payload and register widths
    localparam int CODE_W     = 8;
    localparam int FROW_W     = 4;
    localparam int BITS_W     = 8;
    localparam int PX_W       = 13;
    localparam int CMP_W      = 16;
    localparam int IDX_W      = 24;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Glyph cells are always eight pixels wide
    localparam int GLYPH_COLS = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd3;

    // Register reset values
    localparam logic [PX_W-1:0]    RST_WIDTH  = 13'd800;
    localparam logic [PX_W-1:0]    RST_HEIGHT = 13'd480;
    localparam logic [COLOR_W-1:0] RST_COLOR  = 32'hFFFF_FFFF;

    // Character codes with a meaning of their own
    localparam logic [CODE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CHAR_QMARK = 8'h3F;

    // Input func codes
    localparam logic FUNC_LOAD = 1'b0;

    // Microcode: datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_ACCEPT  = 4'd0;  // take an input beat
    localparam logic [OP_W-1:0] OP_PROBE0  = 4'd1;  // blank test row 0, line offset
    localparam logic [OP_W-1:0] OP_PROBE1  = 4'd2;  // blank test row 1, line * stride
    localparam logic [OP_W-1:0] OP_PROBE2  = 4'd3;  // blank test row 2, add column
    localparam logic [OP_W-1:0] OP_SELECT  = 4'd4;  // pick glyph, rewind row
    localparam logic [OP_W-1:0] OP_EMIT    = 4'd5;  // one row write per free slot
    localparam logic [OP_W-1:0] OP_ADVANCE = 4'd6;  // step cursor, wrap column
    localparam logic [OP_W-1:0] OP_NEWLINE = 4'd7;
    localparam logic [OP_W-1:0] OP_RETURN  = 4'd8;
    localparam logic [OP_W-1:0] OP_WRAP    = 4'd9;  // wrap line at screen height
    localparam logic [OP_W-1:0] OP_FONTWR  = 4'd10;

    // Microcode: next-step conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;  // fall through
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;  // jump
    localparam logic [COND_W-1:0] COND_WAIT     = 3'd2;  // jump while no input beat
    localparam logic [COND_W-1:0] COND_DISPATCH = 3'd3;  // multi-way on the item
    localparam logic [COND_W-1:0] COND_OOB      = 3'd4;  // jump if cell off screen
    localparam logic [COND_W-1:0] COND_MORE     = 3'd5;  // jump until last row sent

    // Microcode addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] P_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] P_DISP  = 4'd1;
    localparam logic [PC_W-1:0] P_PRB1  = 4'd2;
    localparam logic [PC_W-1:0] P_PRB2  = 4'd3;
    localparam logic [PC_W-1:0] P_SEL   = 4'd4;
    localparam logic [PC_W-1:0] P_EMIT  = 4'd5;
    localparam logic [PC_W-1:0] P_ADV   = 4'd6;
    localparam logic [PC_W-1:0] P_LF    = 4'd7;
    localparam logic [PC_W-1:0] P_CR    = 4'd8;
    localparam logic [PC_W-1:0] P_WRAP  = 4'd9;
    localparam logic [PC_W-1:0] P_FONT  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } uc_word_t;

    // Control store
    function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
        uc_word_t w;
        unique case (pc)
            P_IDLE:  w = '{op: OP_ACCEPT,  cond: COND_WAIT,     target: P_IDLE};
            P_DISP:  w = '{op: OP_PROBE0,  cond: COND_DISPATCH, target: P_IDLE};
            P_PRB1:  w = '{op: OP_PROBE1,  cond: COND_NEXT,     target: P_IDLE};
            P_PRB2:  w = '{op: OP_PROBE2,  cond: COND_NEXT,     target: P_IDLE};
            P_SEL:   w = '{op: OP_SELECT,  cond: COND_OOB,      target: P_ADV};
            P_EMIT:  w = '{op: OP_EMIT,    cond: COND_MORE,     target: P_EMIT};
            P_ADV:   w = '{op: OP_ADVANCE, cond: COND_ALWAYS,   target: P_WRAP};
            P_LF:    w = '{op: OP_NEWLINE, cond: COND_ALWAYS,   target: P_WRAP};
            P_CR:    w = '{op: OP_RETURN,  cond: COND_NEXT,     target: P_IDLE};
            P_WRAP:  w = '{op: OP_WRAP,    cond: COND_ALWAYS,   target: P_IDLE};
            P_FONT:  w = '{op: OP_FONTWR,  cond: COND_ALWAYS,   target: P_IDLE};
            default: w = '{op: OP_WRAP,    cond: COND_ALWAYS,   target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/text_console_glyph_renderer.sv
// text_console_glyph_renderer: text console that turns character beats into
// framebuffer row writes, run by a small microcoded sequencer.
// Depends on tcgr_pkg (widths, codes, control store).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready    | s_func, s_char_code, s_font_row, s_font_bits
//  m_      | out       | m_valid / m_ready    | m_pixel_index, m_pixel_mask, m_color,
//          |           |                      | m_last_row
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Steps per input beat: accept, then dispatch. A font load then writes the font row;
//   a disabled character goes back to idle; a line feed or carriage return steps the
//   cursor and then wraps the line; an off-screen character is probed, selected,
//   advanced and wrapped; a drawn character also runs the emit loop before the advance.
// The emit loop reads one glyph row from the font memory port and sends one result beat
// per cycle while no row beat is held with m_ready low.
// Reset (aresetn, synchronous) clears sequencer, cursor, configuration registers and m_valid;
// the font memory is not cleared and must be loaded before use.
// cfg_ready is always high.
module text_console_glyph_renderer #(
    parameter int GLYPH_ROWS    = 16,
    parameter int GLYPH_COUNT   = 256,
    parameter int MAX_SCREEN_PX = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [tcgr_pkg::CODE_W-1:0]        s_char_code,
    input  logic [tcgr_pkg::FROW_W-1:0]        s_font_row,
    input  logic [tcgr_pkg::BITS_W-1:0]        s_font_bits,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tcgr_pkg::IDX_W-1:0]         m_pixel_index,
    output logic [tcgr_pkg::BITS_W-1:0]        m_pixel_mask,
    output logic [tcgr_pkg::COLOR_W-1:0]       m_color,
    output logic                               m_last_row,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tcgr_pkg::*;

    localparam int COL_W  = $clog2(MAX_SCREEN_PX / GLYPH_COLS);
    localparam int LINE_W = $clog2(MAX_SCREEN_PX / GLYPH_ROWS);
    localparam int ROW_W  = $clog2(GLYPH_ROWS);
    localparam int GI_W   = $clog2(GLYPH_COUNT);
    localparam int DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW     = $clog2(DEPTH);

    localparam logic [CODE_W:0]  COUNT_X  = (CODE_W + 1)'(GLYPH_COUNT);
    localparam logic [PX_W-1:0]  MAX_PX   = PX_W'(MAX_SCREEN_PX);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    // Glyph index: character code modulo the glyph count (count >= half the code space)
    function automatic logic [GI_W-1:0] glyph_of(input logic [CODE_W-1:0] c);
        logic [CODE_W:0] ce;
        ce = {1'b0, c};
        if (ce >= COUNT_X) begin
            ce = ce - COUNT_X;
        end
        return ce[GI_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PX_W-1:0]    width_reg;
    logic [PX_W-1:0]    height_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            color_reg  <= RST_COLOR;
            enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[PX_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[PX_W-1:0];
                REG_COLOR:  color_reg  <= cfg_data[COLOR_W-1:0];
                REG_ENABLE: enable_reg <= cfg_data[0];
            endcase
        end
    end

    // Oversized screens are clamped
    logic [PX_W-1:0] w_eff;
    logic [PX_W-1:0] h_eff;
    assign w_eff = (width_reg  > MAX_PX) ? MAX_PX : width_reg;
    assign h_eff = (height_reg > MAX_PX) ? MAX_PX : height_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    logic [PC_W-1:0]   pc_reg, pc_next;
    uc_word_t          uc;

    logic              func_reg, func_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [FROW_W-1:0] frow_reg, frow_next;
    logic [BITS_W-1:0] bits_reg, bits_next;

    logic [GI_W-1:0]   glyph_reg, glyph_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [BITS_W-1:0] acc_reg, acc_next;     // OR of the first three glyph rows
    logic [PX_W-1:0]   lpx_reg, lpx_next;     // line * GLYPH_ROWS
    logic [IDX_W-1:0]  base_reg, base_next;   // index of the cell's top-left pixel
    logic [IDX_W-1:0]  idx_reg, idx_next;     // index of the row being sent

    logic [COL_W-1:0]  x_reg, x_next;
    logic [LINE_W-1:0] y_reg, y_next;

    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   m_index_reg;
    logic [BITS_W-1:0]  m_mask_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_last_reg;

    logic [BITS_W-1:0] rd_data_reg;           // always holds glyph_reg / row_reg
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              font_we;

    logic               out_free;
    logic               emit;
    logic               row_last;
    logic               cell_oob;
    logic               line_over;
    logic               col_full;
    logic               use_qmark;
    logic [COL_W:0]     x_inc;
    logic [2*PX_W-1:0]  prod;

    assign uc       = uc_rom(pc_reg);
    assign s_ready  = (uc.op == OP_ACCEPT);
    assign out_free = !m_valid_reg || m_ready;
    assign row_last = (row_reg == ROW_LAST);

    assign cell_oob  = (CMP_W'((int'(x_reg) + 1) * GLYPH_COLS) > CMP_W'(w_eff))
                    || (CMP_W'((int'(y_reg) + 1) * GLYPH_ROWS) > CMP_W'(h_eff));
    assign line_over = CMP_W'((int'(y_reg) + 1) * GLYPH_ROWS) > CMP_W'(h_eff);
    assign x_inc     = (COL_W + 1)'(x_reg) + (COL_W + 1)'(1);
    assign col_full  = CMP_W'((int'(x_inc) + 1) * GLYPH_COLS) > CMP_W'(w_eff);
    assign use_qmark = (acc_reg == '0) && (code_reg != CHAR_SPACE) && (code_reg != CHAR_NUL);
    assign prod      = lpx_reg * w_eff;

    always_comb begin
        func_next    = func_reg;
        code_next    = code_reg;
        frow_next    = frow_reg;
        bits_next    = bits_reg;
        glyph_next   = glyph_reg;
        row_next     = row_reg;
        acc_next     = acc_reg;
        lpx_next     = lpx_reg;
        base_next    = base_reg;
        idx_next     = idx_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        emit         = 1'b0;
        font_we      = 1'b0;

        unique case (uc.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    func_next  = s_func;
                    code_next  = s_char_code;
                    frow_next  = s_font_row;
                    bits_next  = s_font_bits;
                    glyph_next = glyph_of(s_char_code);
                    row_next   = '0;
                    acc_next   = '0;
                end
            end
            // The first probe runs on every item; probe results are only used for glyphs
            OP_PROBE0: begin
                acc_next = acc_reg | rd_data_reg;
                row_next = row_reg + ROW_W'(1);
                lpx_next = PX_W'(int'(y_reg) * GLYPH_ROWS);
            end
            OP_PROBE1: begin
                acc_next  = acc_reg | rd_data_reg;
                row_next  = row_reg + ROW_W'(1);
                base_next = prod[IDX_W-1:0];
            end
            OP_PROBE2: begin
                acc_next  = acc_reg | rd_data_reg;
                base_next = base_reg + IDX_W'(int'(x_reg) * GLYPH_COLS);
            end
            OP_SELECT: begin
                if (use_qmark) begin
                    glyph_next = glyph_of(CHAR_QMARK);
                end
                row_next = '0;
                idx_next = base_reg;
            end
            OP_EMIT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    idx_next = idx_reg + IDX_W'(w_eff);
                    row_next = row_reg + ROW_W'(1);
                end
            end
            OP_ADVANCE: begin
                if (col_full) begin
                    x_next = '0;
                    y_next = y_reg + LINE_W'(1);
                end else begin
                    x_next = x_inc[COL_W-1:0];
                end
            end
            // y + 1 only overflows from the last possible line, which wraps to 0
            OP_NEWLINE: begin
                x_next = '0;
                y_next = y_reg + LINE_W'(1);
            end
            OP_RETURN: begin
                x_next = '0;
            end
            OP_WRAP: begin
                if (line_over) begin
                    y_next = '0;
                end
            end
            OP_FONTWR: begin
                font_we = (int'(frow_reg) < GLYPH_ROWS);
            end
            default: begin
            end
        endcase
    end

    // Next step
    always_comb begin
        pc_next = pc_reg + PC_W'(1);
        unique case (uc.cond)
            COND_NEXT:   pc_next = pc_reg + PC_W'(1);
            COND_ALWAYS: pc_next = uc.target;
            COND_WAIT: begin
                if (!s_valid) begin
                    pc_next = uc.target;
                end
            end
            COND_DISPATCH: begin
                priority if (func_reg == FUNC_LOAD) begin
                    pc_next = P_FONT;
                end else if (!enable_reg) begin
                    pc_next = P_IDLE;
                end else if (code_reg == CHAR_LF) begin
                    pc_next = P_LF;
                end else if (code_reg == CHAR_CR) begin
                    pc_next = P_CR;
                end else begin
                    pc_next = pc_reg + PC_W'(1);
                end
            end
            COND_OOB: begin
                if (cell_oob) begin
                    pc_next = uc.target;
                end
            end
            COND_MORE: begin
                if (!(out_free && row_last)) begin
                    pc_next = uc.target;
                end
            end
            default: pc_next = P_IDLE;
        endcase
    end

    // Output stage
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= P_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        code_reg  <= code_next;
        frow_reg  <= frow_next;
        bits_reg  <= bits_next;
        glyph_reg <= glyph_next;
        row_reg   <= row_next;
        acc_reg   <= acc_next;
        lpx_reg   <= lpx_next;
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        if (emit) begin
            m_index_reg <= idx_reg;
            m_mask_reg  <= rd_data_reg;
            m_color_reg <= color_reg;
            m_last_reg  <= row_last;
        end
    end

    // ------------------------------------------------------------------
    // Font memory: one write port, one registered read port. The read is
    // addressed from the next glyph/row so that rd_data_reg always matches
    // glyph_reg/row_reg: one row per cycle in the emit loop unless it stalls.
    // ------------------------------------------------------------------
    logic [BITS_W-1:0] font_mem [DEPTH];

    assign rd_addr = AW'(int'(glyph_next) * GLYPH_ROWS + int'(row_next));
    assign wr_addr = AW'(int'(glyph_reg) * GLYPH_ROWS + int'(frow_reg));

    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[wr_addr] <= bits_reg;
        end
        rd_data_reg <= font_mem[rd_addr];
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = m_index_reg;
    assign m_pixel_mask  = m_mask_reg;
    assign m_color       = m_color_reg;
    assign m_last_row    = m_last_reg;

`ifndef ASSERT_OFF
    // The last row beat of a cell hands over to the cursor advance
    a_last_then_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && row_last) |=> (pc_reg == P_ADV))
        else $error("last row sent but sequencer did not advance the cursor");

    // After the line wrap step the cursor line lies on screen, or is line 0
    a_line_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == P_WRAP) |=> ((y_reg == '0) || !line_over))
        else $error("cursor line left off screen after wrap");

    // A result beat only appears out of the emit step
    a_beat_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(pc_reg) == P_EMIT))
        else $error("result beat raised outside the emit step");
`endif

endmodule
